// ===== rtl/core/ptds_pkg.sv =====
// shared constants, types and the name table of the token dictionary scan
package ptds_pkg;

   localparam int CHUNK_BYTES = 1048576;
   localparam int MAX_TOKEN   = 15;
   localparam int TAIL_GUARD  = 16;
   localparam int NAME_COUNT  = 9;

   localparam int BYTE_BITS   = 8;
   localparam int ADDR_BITS   = 48;
   localparam int COUNT_BITS  = 16;
   localparam int INDEX_BITS  = 4;
   localparam int LEN_BITS    = $clog2(MAX_TOKEN + 1);
   localparam int SLOT_BITS   = $clog2(MAX_TOKEN);
   localparam int OFFSET_BITS = $clog2(CHUNK_BYTES);

   // chunk size is a power of two, so the offset is the low address bits
   localparam logic [OFFSET_BITS-1:0] OPEN_LIMIT = OFFSET_BITS'(CHUNK_BYTES - TAIL_GUARD);
   localparam logic [OFFSET_BITS-1:0] CHUNK_LAST = OFFSET_BITS'(CHUNK_BYTES - 1);
   localparam logic [LEN_BITS-1:0]    TOKEN_CAP  = LEN_BITS'(MAX_TOKEN);

   localparam logic [BYTE_BITS-1:0]  SPACE_CHAR   = 8'd32;
   localparam logic [BYTE_BITS-1:0]  TILDE_CHAR   = 8'd126;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
   localparam logic [COUNT_BITS-1:0] LIMIT_RESET  = 16'd500;

   typedef logic [MAX_TOKEN-1:0][BYTE_BITS-1:0] token_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic [ADDR_BITS-1:0] byte_address;
   } beat_type;

   localparam logic [MAX_TOKEN*BYTE_BITS-1:0] NAME_STR [NAME_COUNT] = '{
      "systemd", "init", "bash", "sshd", "kernel",
      "kthreadd", "python", "java", "systemd-journal"
   };

   localparam int NAME_LEN [NAME_COUNT] = '{7, 4, 4, 4, 6, 8, 6, 4, 15};

   // byte i of name k, counted from its first character
   function automatic logic [BYTE_BITS-1:0] name_char(input int k, input int i);
      logic [BYTE_BITS-1:0] result;
      result = '0;
      if (i < NAME_LEN[k]) begin
         result = NAME_STR[k][(NAME_LEN[k] - 1 - i) * BYTE_BITS +: BYTE_BITS];
      end
      return result;
   endfunction

endpackage

// ===== rtl/core/ptds_channels.sv =====
// valid/ready channel interfaces for byte requests and match responses
interface ptds_req_if import ptds_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic [ADDR_BITS-1:0] byte_address;

   modport source (output valid, output data_byte, output byte_address, input ready);
   modport sink   (input valid, input data_byte, input byte_address, output ready);
endinterface

interface ptds_rsp_if import ptds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] word_index;
   logic [ADDR_BITS-1:0]  match_address;
   logic [COUNT_BITS-1:0] match_total;

   modport source (output valid, output word_index, output match_address,
                   output match_total, input ready);
   modport sink   (input valid, input word_index, input match_address,
                   input match_total, output ready);
endinterface

// ===== rtl/core/printable_token_dictionary_scan.sv =====
// Printable token dictionary scan: takes one memory byte with its address per cycle and
// reports each printable token that equals one of nine fixed process names, until a chunk
// starts with the match count at or above match_limit. A byte transfer is taken every
// cycle while the response side keeps up; the match response for a closing byte passes
// the input register, then the tokenizer and nine parallel comparators into the response
// register. A stalled response holds the whole path, one register deep on each side. The
// tokenizer takes each byte as it arrives, so consecutive bytes need no spacing. No clearing
// pass follows reset. match_limit may be written only while no bytes are in flight.
module printable_token_dictionary_scan import ptds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ptds_req_if.sink              req_channel,
   ptds_rsp_if.source            rsp_channel,
   input  logic                  csr_write_enable,
   input  logic [COUNT_BITS-1:0] csr_write_data
);

   logic [COUNT_BITS-1:0] match_limit_ff;
   logic [COUNT_BITS-1:0] match_limit_in;
   logic                  beat_valid;
   beat_type              beat;
   logic                  advance;

   assign match_limit_in = csr_write_enable ? csr_write_data : match_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_limit_ff <= LIMIT_RESET;
      end else begin
         match_limit_ff <= match_limit_in;
      end
   end

   ptds_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_channel),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   ptds_scan_core u_scan_core (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (beat_valid),
      .beat        (beat),
      .advance     (advance),
      .match_limit (match_limit_ff),
      .rsp         (rsp_channel)
   );

endmodule

// ===== rtl/core/ptds_input_stage.sv =====
// input register for incoming byte transfers
module ptds_input_stage import ptds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ptds_req_if.sink    req,
   input  logic        advance,
   output logic        beat_valid,
   output beat_type    beat
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;
   beat_type beat_in;

   assign req.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (req.ready) begin
         valid_in = req.valid;
         beat_in  = '{data_byte: req.data_byte, byte_address: req.byte_address};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

// ===== rtl/core/ptds_name_match.sv =====
// parallel compare of a closed token against the fixed name table
module ptds_name_match import ptds_pkg::*; (
   input  token_type             token,
   input  logic [LEN_BITS-1:0]   token_length,
   output logic                  hit,
   output logic [INDEX_BITS-1:0] word_index
);

   logic [NAME_COUNT-1:0] name_hit;

   always_comb begin
      for (int k = 0; k < NAME_COUNT; k++) begin
         name_hit[k] = (token_length == LEN_BITS'(NAME_LEN[k]));
         for (int i = 0; i < MAX_TOKEN; i++) begin
            if (i < NAME_LEN[k] && token[i] != name_char(k, i)) begin
               name_hit[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hit        = 1'b0;
      word_index = '0;
      for (int k = NAME_COUNT - 1; k >= 0; k--) begin
         if (name_hit[k]) begin
            hit        = 1'b1;
            word_index = INDEX_BITS'(k);
         end
      end
   end

endmodule

// ===== rtl/core/ptds_scan_core.sv =====
// tokenizer state, match counting and the response register
module ptds_scan_core import ptds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat_valid,
   input  beat_type              beat,
   output logic                  advance,
   input  logic [COUNT_BITS-1:0] match_limit,
   ptds_rsp_if.source            rsp
);

   token_type             token_ff;
   token_type             token_in;
   logic [LEN_BITS-1:0]   length_ff;
   logic [LEN_BITS-1:0]   length_in;
   logic [ADDR_BITS-1:0]  start_ff;
   logic [ADDR_BITS-1:0]  start_in;
   logic                  skip_ff;
   logic                  skip_in;
   logic [COUNT_BITS-1:0] found_ff;
   logic [COUNT_BITS-1:0] found_in;
   logic                  halted_ff;
   logic                  halted_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [INDEX_BITS-1:0] rsp_index_ff;
   logic [INDEX_BITS-1:0] rsp_index_in;
   logic [ADDR_BITS-1:0]  rsp_address_ff;
   logic [ADDR_BITS-1:0]  rsp_address_in;
   logic [COUNT_BITS-1:0] rsp_total_ff;
   logic [COUNT_BITS-1:0] rsp_total_in;

   logic [OFFSET_BITS-1:0] offset;
   logic                   chunk_start;
   logic                   printable;
   logic [LEN_BITS-1:0]    open_length;
   logic [LEN_BITS-1:0]    cand_length;
   logic                   close;
   logic                   hit;
   logic [INDEX_BITS-1:0]  hit_index;

   assign advance     = beat_valid && (!rsp_valid_ff || rsp.ready);
   assign offset      = beat.byte_address[OFFSET_BITS-1:0];
   assign chunk_start = (offset == '0);
   assign printable   = (beat.data_byte >= SPACE_CHAR) && (beat.data_byte <= TILDE_CHAR);
   assign open_length = chunk_start ? '0 : length_ff;

   ptds_name_match u_name_match (
      .token        (token_in),
      .token_length (cand_length),
      .hit          (hit),
      .word_index   (hit_index)
   );

   always_comb begin
      token_in    = token_ff;
      start_in    = start_ff;
      skip_in     = skip_ff;
      halted_in   = halted_ff;
      cand_length = length_ff;
      close       = 1'b0;
      if (advance && !halted_ff) begin
         cand_length = open_length;
         skip_in     = 1'b0;
         if (chunk_start && found_ff >= match_limit) begin
            halted_in = 1'b1;
         end else if (skip_ff && !chunk_start) begin
            skip_in = 1'b0;
         end else begin
            if (open_length == '0) begin
               if (printable && beat.data_byte != SPACE_CHAR && offset < OPEN_LIMIT) begin
                  token_in[0] = beat.data_byte;
                  cand_length = LEN_BITS'(1);
                  start_in    = beat.byte_address;
               end
            end else if (printable) begin
               token_in[open_length[SLOT_BITS-1:0]] = beat.data_byte;
               cand_length = open_length + LEN_BITS'(1);
               if (cand_length == TOKEN_CAP) begin
                  close   = 1'b1;
                  skip_in = 1'b1;
               end
            end else begin
               close = 1'b1;
            end
            if (cand_length != '0 && offset == CHUNK_LAST) begin
               close = 1'b1;
            end
         end
      end
      length_in = close ? '0 : cand_length;
   end

   always_comb begin
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_index_in   = rsp_index_ff;
      rsp_address_in = rsp_address_ff;
      rsp_total_in   = rsp_total_ff;
      if (advance) begin
         rsp_valid_in = close && hit;
      end
      if (close && hit) begin
         if (found_ff != COUNT_MAX) begin
            found_in = found_ff + COUNT_BITS'(1);
         end
         rsp_index_in   = hit_index;
         rsp_address_in = start_in;
         rsp_total_in   = found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff     <= '0;
         length_ff    <= '0;
         start_ff     <= '0;
         skip_ff      <= 1'b0;
         found_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         token_ff     <= token_in;
         length_ff    <= length_in;
         start_ff     <= start_in;
         skip_ff      <= skip_in;
         found_ff     <= found_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff   <= rsp_index_in;
      rsp_address_ff <= rsp_address_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.word_index    = rsp_index_ff;
   assign rsp.match_address = rsp_address_ff;
   assign rsp.match_total   = rsp_total_ff;

endmodule

// ===== rtl/core/ptds_checker.sv =====
// port-level assertions for the token dictionary scan, bound to the top level
module ptds_checker import ptds_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [INDEX_BITS-1:0] rsp_word_index,
   input logic [ADDR_BITS-1:0]  rsp_match_address,
   input logic [COUNT_BITS-1:0] rsp_match_total
);

   // stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_address)
         && $stable(rsp_match_total) && $stable(rsp_word_index))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_total != '0 && rsp_word_index < INDEX_BITS'(NAME_COUNT))
      else $error("response carries an impossible index or count");

   // no response out of reset before a byte could have been taken
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

   // a rising response needs an earlier request transfer or a stalled request side
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_valid && req_ready, 2) || $past(req_valid && req_ready, 3)
            || !$past(req_ready, 2))
      else $error("response without a preceding request transfer");

endmodule

bind printable_token_dictionary_scan ptds_checker u_ptds_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_channel.valid),
   .req_ready         (req_channel.ready),
   .rsp_valid         (rsp_channel.valid),
   .rsp_ready         (rsp_channel.ready),
   .rsp_word_index    (rsp_channel.word_index),
   .rsp_match_address (rsp_channel.match_address),
   .rsp_match_total   (rsp_channel.match_total)
);

// ===== tb/tb_printable_token_dictionary_scan.sv =====
// self-checking testbench for the printable token dictionary scan
`timescale 1ns / 100ps

module tb_printable_token_dictionary_scan;
   import ptds_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [INDEX_BITS-1:0] word_index;
      logic [ADDR_BITS-1:0]  match_address;
      logic [COUNT_BITS-1:0] match_total;
   } match_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [COUNT_BITS-1:0] csr_write_data;

   ptds_req_if req_bus ();
   ptds_rsp_if rsp_bus ();

   printable_token_dictionary_scan dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   string proc_names [NAME_COUNT] = '{
      "systemd", "init", "bash", "sshd", "kernel",
      "kthreadd", "python", "java", "systemd-journal"
   };
   int short_ids [4] = '{1, 2, 3, 7};

   // scanner shadow state
   logic [BYTE_BITS-1:0]  tok_text [MAX_TOKEN];
   logic [LEN_BITS-1:0]   tok_len = '0;
   logic [ADDR_BITS-1:0]  tok_addr = '0;
   bit                    drop_next = 1'b0;
   logic [COUNT_BITS-1:0] match_count = '0;
   bit                    scan_stopped = 1'b0;
   logic [COUNT_BITS-1:0] limit_value = LIMIT_RESET;

   match_type            predicted_matches [$];
   beat_type             byte_queue [$];
   beat_type             head_beat;
   logic [ADDR_BITS-1:0] cursor;
   bit                   steady = 1'b0;
   int                   error_count = 0;
   int                   bytes_taken = 0;
   int                   matches_checked = 0;
   int                   stall_cycles = 0;

   function automatic void close_token();
      logic [LEN_BITS-1:0] n;
      bit                  same;
      match_type           m;
      n = tok_len;
      tok_len = '0;
      if (n < 3) return;
      for (int k = 0; k < NAME_COUNT; k++) begin
         if (proc_names[k].len() == int'(n)) begin
            same = 1'b1;
            for (int i = 0; i < int'(n); i++) begin
               if (tok_text[i] != proc_names[k][i]) same = 1'b0;
            end
            if (same) begin
               if (match_count != COUNT_MAX) match_count++;
               m.word_index    = INDEX_BITS'(k);
               m.match_address = tok_addr;
               m.match_total   = match_count;
               predicted_matches.push_back(m);
               return;
            end
         end
      end
   endfunction

   function automatic void scan_byte(input logic [BYTE_BITS-1:0] b,
                                     input logic [ADDR_BITS-1:0] a);
      logic [OFFSET_BITS-1:0] off;
      bit                     printable;
      off = a[OFFSET_BITS-1:0];
      printable = (b >= SPACE_CHAR) && (b <= TILDE_CHAR);
      if (scan_stopped) return;
      if (off == '0) begin
         tok_len = '0;
         drop_next = 1'b0;
         if (match_count >= limit_value) begin
            scan_stopped = 1'b1;
            return;
         end
      end
      if (drop_next) begin
         drop_next = 1'b0;
         return;
      end
      if (tok_len == '0) begin
         if (printable && b > SPACE_CHAR && off < OPEN_LIMIT) begin
            tok_text[0] = b;
            tok_len = LEN_BITS'(1);
            tok_addr = a;
         end
      end else if (printable) begin
         if (tok_len < TOKEN_CAP) begin
            tok_text[tok_len] = b;
            tok_len++;
         end
         if (tok_len >= TOKEN_CAP) begin
            close_token();
            drop_next = 1'b1;
         end
      end else begin
         close_token();
      end
      if (tok_len != '0 && off == CHUNK_LAST) close_token();
   endfunction

   function automatic void push_byte(input logic [BYTE_BITS-1:0] b);
      beat_type beat;
      beat.data_byte = b;
      beat.byte_address = cursor;
      byte_queue.push_back(beat);
      cursor++;
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [BYTE_BITS-1:0] pick_nonprint();
      int r;
      r = $urandom_range(160);
      return (r < 32) ? BYTE_BITS'(r) : BYTE_BITS'(r + 95);
   endfunction

   function automatic logic [ADDR_BITS-1:0] random_address();
      return ADDR_BITS'({$urandom, $urandom});
   endfunction

   function automatic void add_random_segment();
      int    pick;
      int    n;
      string word;
      pick = $urandom_range(99);
      if (pick < 50) begin
         word = proc_names[$urandom_range(NAME_COUNT - 1)];
         if ($urandom_range(99) < 12) begin
            word[$urandom_range(word.len() - 1)] = byte'($urandom_range(33, 126));
         end else if ($urandom_range(99) < 8) begin
            word = word.substr(0, word.len() - 2);
         end
         push_text(word);
         if ($urandom_range(99) < 20) push_byte(SPACE_CHAR);
         else push_byte(pick_nonprint());
      end else if (pick < 65) begin
         n = $urandom_range(1, 20);
         repeat (n) push_byte(BYTE_BITS'($urandom_range(32, 126)));
         push_byte(pick_nonprint());
      end else if (pick < 80) begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(BYTE_BITS'($urandom_range(255)));
      end else if (pick < 90) begin
         cursor = random_address();
         cursor[OFFSET_BITS-1:0] = OFFSET_BITS'(CHUNK_BYTES - 1 - $urandom_range(23));
      end else if (pick < 95) begin
         cursor = random_address();
      end else begin
         cursor = random_address();
         cursor[OFFSET_BITS-1:0] = '0;
      end
   endfunction

   task automatic check_match();
      match_type want;
      if (predicted_matches.size() == 0) begin
         $display("%0t: unexpected match, expected none, got word %0d at %h total %0d",
                  $time, rsp_bus.word_index, rsp_bus.match_address, rsp_bus.match_total);
         error_count++;
      end else begin
         want = predicted_matches.pop_front();
         matches_checked++;
         if (rsp_bus.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d got %0d",
                     $time, want.word_index, rsp_bus.word_index);
            error_count++;
         end
         if (rsp_bus.match_address !== want.match_address) begin
            $display("%0t: match_address expected %h got %h",
                     $time, want.match_address, rsp_bus.match_address);
            error_count++;
         end
         if (rsp_bus.match_total !== want.match_total) begin
            $display("%0t: match_total expected %0d got %0d",
                     $time, want.match_total, rsp_bus.match_total);
            error_count++;
         end
      end
   endtask

   task automatic drain();
      while (byte_queue.size() != 0 || req_bus.valid || predicted_matches.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_match_limit(input logic [COUNT_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      limit_value = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // byte transfer driver, predicts on each accepted byte
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= '0;
         req_bus.byte_address <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            scan_byte(req_bus.data_byte, req_bus.byte_address);
            bytes_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
               head_beat = byte_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.data_byte <= head_beat.data_byte;
               req_bus.byte_address <= head_beat.byte_address;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // match transfer monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_match();
         rsp_bus.ready <= steady || ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_write_enable) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("tb_printable_token_dictionary_scan: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int need;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // capped name with skipped byte, chunk end close, chunk start discard
      cursor = '0;
      push_text("systemd-journal");
      push_text("bash");
      push_byte(8'h00);
      cursor = 48'hFFFF_FFF0_0005;
      push_text("jav");
      cursor = '1;
      push_text("a");
      cursor = 48'h0000_1234_5670;
      push_text("p");
      cursor = 48'h0000_1240_0000;
      push_text("sshd");
      push_byte(8'hFF);
      drain();

      set_match_limit(COUNT_MAX);
      cursor = random_address();
      while (byte_queue.size() < 1200) add_random_segment();
      drain();

      // long steady stretch of back to back names
      set_match_limit(COUNT_BITS'($urandom_range(1000, 60000)));
      steady = 1'b1;
      cursor = random_address();
      cursor[OFFSET_BITS-1:0] = '0;
      need = 50;
      for (int i = 0; i < need; i++) begin
         push_text(proc_names[short_ids[i % 4]]);
         push_byte(pick_nonprint());
      end
      drain();
      steady = 1'b0;

      set_match_limit('0);
      push_text("bash");
      push_byte(8'h00);
      cursor = random_address();
      cursor[OFFSET_BITS-1:0] = '0;
      push_text("init");
      push_byte(8'h00);
      repeat (20) add_random_segment();
      drain();
      repeat (10) @(posedge clock);

      $display("scanned %0d bytes and compared %0d matches; final count %0d, stopped %0b",
               bytes_taken, matches_checked, match_count, scan_stopped);
      if (error_count == 0) begin
         $display("tb_printable_token_dictionary_scan: clean");
      end else begin
         $display("tb_printable_token_dictionary_scan: errors");
      end
      $finish;
   end

endmodule
